### rtl/core/source_code_lexer_top_assert.svh
// Assertion macros for the lexer checker.
`ifndef SOURCE_CODE_LEXER_TOP_ASSERT_SVH
`define SOURCE_CODE_LEXER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SCL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define SCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/core/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types, token kinds and helpers of the source code lexer.
// ----------------------------------------------------------------------------
package scl_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int KEYWORD_MAX_LEN = 9;
	localparam int LEN_CNT_W = $clog2(KEYWORD_MAX_LEN + 1);
	localparam logic [COORD_WIDTH-1:0] COORD_MAX = {COORD_WIDTH{1'b1}};
	localparam logic [COORD_WIDTH-1:0] COORD_ONE = COORD_WIDTH'(1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

	localparam logic [5:0] K_IDENT    = 6'd0;
	localparam logic [5:0] K_NUMBER   = 6'd16;
	localparam logic [5:0] K_FLOATNUM = 6'd17;
	localparam logic [5:0] K_STRING   = 6'd18;
	localparam logic [5:0] K_CHARLIT  = 6'd19;
	localparam logic [5:0] K_ASSIGN   = 6'd34;
	localparam logic [5:0] K_EQ       = 6'd35;
	localparam logic [5:0] K_NE       = 6'd36;
	localparam logic [5:0] K_END      = 6'd37;
	localparam logic [5:0] K_ERROR    = 6'd38;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_STRING = 2'd1;
	localparam logic [1:0] ERR_CHAR   = 2'd2;
	localparam logic [1:0] ERR_BANG   = 2'd3;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	typedef struct packed {
		logic [5:0]             token_kind;
		logic [COORD_WIDTH-1:0] start_line;
		logic [COORD_WIDTH-1:0] start_column;
		logic [COORD_WIDTH-1:0] token_length;
		logic [7:0]             char_code;
		logic [1:0]             error_code;
		logic                   last_of_item;
	} token_t;

	typedef struct packed {
		logic   valid;
		token_t tok;
	} tok_slot_t;

	// Up to two results of one request, in order.
	typedef struct packed {
		tok_slot_t first;
		tok_slot_t second;
	} tok_pair_t;

	typedef logic [KEYWORD_MAX_LEN*8-1:0] kbuf_t;

	function automatic logic [COORD_WIDTH-1:0] sat_inc(input logic [COORD_WIDTH-1:0] v);
		return (v == COORD_MAX) ? v : v + COORD_ONE;
	endfunction

	function automatic logic [5:0] single_op(input logic [7:0] c);
		case (c)
			8'h2B: return 6'd20;
			8'h2D: return 6'd21;
			8'h2A: return 6'd22;
			8'h2F: return 6'd23;
			8'h3B: return 6'd24;
			8'h28: return 6'd25;
			8'h29: return 6'd26;
			8'h7B: return 6'd27;
			8'h7D: return 6'd28;
			8'h5B: return 6'd29;
			8'h5D: return 6'd30;
			8'h2C: return 6'd31;
			8'h3E: return 6'd32;
			8'h3C: return 6'd33;
			default: return 6'd0;
		endcase
	endfunction

	function automatic logic kw_match(input kbuf_t b, input logic [LEN_CNT_W-1:0] n,
		input string s);
		logic ok;
		ok = (int'(n) == s.len());
		for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
			if (i < s.len() && b[i*8 +: 8] != s.getc(i)) ok = 1'b0;
		end
		return ok;
	endfunction

	// Reserved word lookup; only lengths up to the buffer size (short_ok) are matched.
	function automatic logic [5:0] keyword_kind(input kbuf_t b,
		input logic [LEN_CNT_W-1:0] n, input logic short_ok);
		logic [5:0] k;
		k = K_IDENT;
		if (short_ok) begin
			if (kw_match(b, n, "if")) k = 6'd1;
			else if (kw_match(b, n, "else")) k = 6'd2;
			else if (kw_match(b, n, "return")) k = 6'd3;
			else if (kw_match(b, n, "print")) k = 6'd4;
			else if (kw_match(b, n, "int")) k = 6'd5;
			else if (kw_match(b, n, "float")) k = 6'd6;
			else if (kw_match(b, n, "char")) k = 6'd7;
			else if (kw_match(b, n, "ComeAndDo")) k = 6'd8;
			else if (kw_match(b, n, "while")) k = 6'd9;
			else if (kw_match(b, n, "for")) k = 6'd10;
			else if (kw_match(b, n, "bool")) k = 6'd11;
			else if (kw_match(b, n, "string")) k = 6'd12;
			else if (kw_match(b, n, "read")) k = 6'd13;
			else if (kw_match(b, n, "input")) k = 6'd14;
			else if (kw_match(b, n, "true")) k = 6'd15;
			else if (kw_match(b, n, "false")) k = 6'd15;
		end
		return k;
	endfunction
endpackage

### rtl/core/scl_if.sv
// ----------------------------------------------------------------------------
// scl_in_if / scl_out_if
// Valid/ready channels for source bytes and tokens.
// ----------------------------------------------------------------------------
interface scl_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] byte_value;
	modport source (output valid, cmd, byte_value, input ready);
	modport sink (input valid, cmd, byte_value, output ready);
endinterface

interface scl_out_if;
	logic                            valid;
	logic                            ready;
	logic [5:0]                      token_kind;
	logic [scl_pkg::COORD_WIDTH-1:0] start_line;
	logic [scl_pkg::COORD_WIDTH-1:0] start_column;
	logic [scl_pkg::COORD_WIDTH-1:0] token_length;
	logic [7:0]                      char_code;
	logic [1:0]                      error_code;
	logic                            last_of_item;
	modport source (output valid, token_kind, start_line, start_column, token_length,
		char_code, error_code, last_of_item, input ready);
	modport sink (input valid, token_kind, start_line, start_column, token_length,
		char_code, error_code, last_of_item, output ready);
endinterface

### rtl/core/scl_front.sv
// ----------------------------------------------------------------------------
// scl_front
// Scanner: accepts one request a cycle while the queue has room, updates position state, emits tokens.
// ----------------------------------------------------------------------------
module scl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [7:0]          byte_value,
	input  logic                room,
	output scl_pkg::tok_pair_t  pair
);
	import scl_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUM_INT, M_NUM_FRAC, M_STRING, M_CHAR_OPEN,
		M_CHAR_HELD, M_EQ_HELD, M_BANG_HELD, M_HALTED
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [COORD_WIDTH-1:0] line_q, line_d, col_q, col_d;
	logic [COORD_WIDTH-1:0] tline_q, tline_d, tcol_q, tcol_d;
	logic [COORD_WIDTH-1:0] len_q, len_d;
	kbuf_t                  kbuf_q, kbuf_d;
	logic [7:0]             held_q, held_d;
	logic                   fire;
	logic                   is_alpha, is_digit;
	logic [5:0]             op, id_kind;
	tok_pair_t              p;

	assign in_ready = room;
	assign fire = in_valid && room;
	assign is_alpha = (byte_value >= 8'h61 && byte_value <= 8'h7A) ||
		(byte_value >= 8'h41 && byte_value <= 8'h5A);
	assign is_digit = byte_value >= 8'h30 && byte_value <= 8'h39;
	assign op = single_op(byte_value);
	assign id_kind = keyword_kind(kbuf_q, len_q[LEN_CNT_W-1:0],
		len_q <= COORD_WIDTH'(KEYWORD_MAX_LEN));

	function automatic token_t mk(input logic [5:0] k, input logic [COORD_WIDTH-1:0] l,
		input logic [COORD_WIDTH-1:0] c, input logic [COORD_WIDTH-1:0] n,
		input logic [7:0] ch, input logic [1:0] e);
		token_t t;
		t.token_kind = k; t.start_line = l; t.start_column = c;
		t.token_length = n; t.char_code = ch; t.error_code = e; t.last_of_item = 1'b0;
		return t;
	endfunction

	always_comb begin
		logic start;
		mode_d = mode_q; line_d = line_q; col_d = col_q; tline_d = tline_q;
		tcol_d = tcol_q; len_d = len_q; kbuf_d = kbuf_q; held_d = held_q;
		p = '0;
		start = 1'b0;
		if (mode_q != M_HALTED) begin
			if (cmd == CMD_END) begin
				case (mode_q)
					M_IDENT: begin
						p.first.valid = 1'b1;
						p.first.tok = mk(id_kind, tline_q, tcol_q, len_q, 8'd0, ERR_NONE);
					end
					M_NUM_INT, M_NUM_FRAC: begin
						p.first.valid = 1'b1;
						p.first.tok = mk(mode_q == M_NUM_FRAC ? K_FLOATNUM : K_NUMBER,
							tline_q, tcol_q, len_q, 8'd0, ERR_NONE);
					end
					M_EQ_HELD: begin
						p.first.valid = 1'b1;
						p.first.tok = mk(K_ASSIGN, tline_q, tcol_q, COORD_ONE, 8'd0, ERR_NONE);
					end
					default: ;
				endcase
				if (mode_q == M_STRING || mode_q == M_CHAR_OPEN || mode_q == M_CHAR_HELD
					|| mode_q == M_BANG_HELD) begin
					p.first.valid = 1'b1;
					p.first.tok = mk(K_ERROR, tline_q, tcol_q, '0, 8'd0,
						mode_q == M_STRING ? ERR_STRING :
						(mode_q == M_BANG_HELD ? ERR_BANG : ERR_CHAR));
					mode_d = M_HALTED;
				end else begin
					p.second.valid = 1'b1;
					p.second.tok = mk(K_END, line_q, col_q, '0, 8'd0, ERR_NONE);
					mode_d = M_IDLE; line_d = COORD_ONE; col_d = COORD_ONE; len_d = '0;
				end
			end else begin
				case (mode_q)
					M_IDENT: begin
						if (is_alpha || is_digit || byte_value == 8'h5F) begin
							for (int i = 0; i < KEYWORD_MAX_LEN; i++)
								if (len_q == COORD_WIDTH'(i)) kbuf_d[i*8 +: 8] = byte_value;
							len_d = sat_inc(len_q); col_d = sat_inc(col_q);
						end else begin
							p.first.valid = 1'b1;
							p.first.tok = mk(id_kind, tline_q, tcol_q, len_q, 8'd0, ERR_NONE);
							start = 1'b1;
						end
					end
					M_NUM_INT, M_NUM_FRAC: begin
						if (is_digit || (byte_value == 8'h2E && mode_q == M_NUM_INT)) begin
							if (byte_value == 8'h2E) mode_d = M_NUM_FRAC;
							len_d = sat_inc(len_q); col_d = sat_inc(col_q);
						end else begin
							p.first.valid = 1'b1;
							p.first.tok = mk(mode_q == M_NUM_FRAC ? K_FLOATNUM : K_NUMBER,
								tline_q, tcol_q, len_q, 8'd0, ERR_NONE);
							start = 1'b1;
						end
					end
					M_STRING: begin
						if (byte_value == 8'h22) begin
							col_d = sat_inc(col_q);
							p.second.valid = 1'b1;
							p.second.tok = mk(K_STRING, tline_q, tcol_q, len_q, 8'd0, ERR_NONE);
							mode_d = M_IDLE;
						end else begin
							if (byte_value == 8'h0A) begin
								line_d = sat_inc(line_q); col_d = COORD_ONE;
							end else col_d = sat_inc(col_q);
							len_d = sat_inc(len_q);
						end
					end
					M_CHAR_OPEN: begin
						held_d = byte_value; col_d = sat_inc(col_q); mode_d = M_CHAR_HELD;
					end
					M_CHAR_HELD: begin
						p.second.valid = 1'b1;
						if (byte_value == 8'h27) begin
							col_d = sat_inc(col_q);
							p.second.tok = mk(K_CHARLIT, tline_q, tcol_q, COORD_ONE, held_q,
								ERR_NONE);
							mode_d = M_IDLE;
						end else begin
							p.second.tok = mk(K_ERROR, tline_q, tcol_q, '0, 8'd0, ERR_CHAR);
							mode_d = M_HALTED;
						end
					end
					M_EQ_HELD: begin
						if (byte_value == 8'h3D) begin
							col_d = sat_inc(col_q);
							p.second.valid = 1'b1;
							p.second.tok = mk(K_EQ, tline_q, tcol_q, COORD_WIDTH'(2), 8'd0,
								ERR_NONE);
							mode_d = M_IDLE;
						end else begin
							p.first.valid = 1'b1;
							p.first.tok = mk(K_ASSIGN, tline_q, tcol_q, COORD_ONE, 8'd0,
								ERR_NONE);
							start = 1'b1;
						end
					end
					M_BANG_HELD: begin
						p.second.valid = 1'b1;
						if (byte_value == 8'h3D) begin
							col_d = sat_inc(col_q);
							p.second.tok = mk(K_NE, tline_q, tcol_q, COORD_WIDTH'(2), 8'd0,
								ERR_NONE);
							mode_d = M_IDLE;
						end else begin
							p.second.tok = mk(K_ERROR, tline_q, tcol_q, '0, 8'd0, ERR_BANG);
							mode_d = M_HALTED;
						end
					end
					default: start = 1'b1;
				endcase
				if (start) begin
					mode_d = M_IDLE; tline_d = line_q; tcol_d = col_q;
					if (byte_value == 8'h0A) begin
						line_d = sat_inc(line_q); col_d = COORD_ONE;
					end else begin
						col_d = sat_inc(col_q);
						if (is_alpha) begin
							mode_d = M_IDENT; kbuf_d[7:0] = byte_value; len_d = COORD_ONE;
						end else if (is_digit) begin
							mode_d = M_NUM_INT; len_d = COORD_ONE;
						end else if (byte_value == 8'h22) begin
							mode_d = M_STRING; len_d = '0;
						end else if (byte_value == 8'h27) mode_d = M_CHAR_OPEN;
						else if (byte_value == 8'h3D) mode_d = M_EQ_HELD;
						else if (byte_value == 8'h21) mode_d = M_BANG_HELD;
						else if (op != 6'd0) begin
							p.second.valid = 1'b1;
							p.second.tok = mk(op, line_q, col_q, COORD_ONE, 8'd0, ERR_NONE);
						end
					end
				end
			end
		end
		// Mark the final result of the request.
		if (p.second.valid) p.second.tok.last_of_item = 1'b1;
		else if (p.first.valid) p.first.tok.last_of_item = 1'b1;
		if (!fire) p = '0;
	end

	assign pair = p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; line_q <= COORD_ONE; col_q <= COORD_ONE;
			tline_q <= COORD_ONE; tcol_q <= COORD_ONE; len_q <= '0;
			kbuf_q <= '0; held_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d; line_q <= line_d; col_q <= col_d;
			tline_q <= tline_d; tcol_q <= tcol_d; len_q <= len_d;
			kbuf_q <= kbuf_d; held_q <= held_d;
		end
	end
endmodule

### rtl/core/scl_queue.sv
// ----------------------------------------------------------------------------
// scl_queue
// Token queue: takes up to two tokens a cycle, hands out one a cycle.
// ----------------------------------------------------------------------------
module scl_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  scl_pkg::tok_pair_t pair,
	output logic               room,
	output logic               q_valid,
	output scl_pkg::token_t    q_tok,
	input  logic               q_pop
);
	import scl_pkg::*;

	token_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] rd_q, wr_q;
	logic [QUEUE_IDX_W:0]   cnt_q;
	logic [1:0]             n_push;
	logic                   pop;

	assign pop = q_pop && q_valid;
	assign n_push = 2'(pair.first.valid) + 2'(pair.second.valid);
	// Room for two more tokens, not counting this cycle's pop.
	assign room = cnt_q <= (QUEUE_IDX_W+1)'(QUEUE_DEPTH - 2);
	assign q_valid = cnt_q != '0;
	assign q_tok = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (pair.first.valid) mem_q[wr_q] <= pair.first.tok;
		if (pair.second.valid)
			mem_q[wr_q + QUEUE_IDX_W'(pair.first.valid)] <= pair.second.tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			wr_q <= wr_q + QUEUE_IDX_W'(n_push);
			rd_q <= rd_q + QUEUE_IDX_W'(pop);
			cnt_q <= cnt_q + (QUEUE_IDX_W+1)'(n_push) - (QUEUE_IDX_W+1)'(pop);
		end
	end
endmodule

### rtl/core/scl_back.sv
// ----------------------------------------------------------------------------
// scl_back
// Output register stage: drains the token queue onto the result channel.
// ----------------------------------------------------------------------------
module scl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  scl_pkg::token_t q_tok,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output scl_pkg::token_t out_tok
);
	import scl_pkg::*;

	logic   valid_q;
	token_t tok_q;

	assign q_pop = q_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_tok = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (!valid_q || out_ready) valid_q <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (q_pop) tok_q <= q_tok;
	end
endmodule

### rtl/core/source_code_lexer_top.sv
// ----------------------------------------------------------------------------
// source_code_lexer_top
// Streaming lexer: source bytes in, tokens with position and length out.
// ----------------------------------------------------------------------------
// One request (a source byte or the end mark) is accepted per cycle while the
// four-entry token queue has room for two more tokens; a request yields zero,
// one or two tokens, and the output side delivers one token per cycle while
// the consumer is ready, so the sustained rate is one request per cycle until
// two-token requests fill the queue, which then limits input to the output's
// one token per cycle. The scanner updates line, column and token start in the
// cycle of acceptance; tokens then pass through the queue and the output
// register. After an error token the block swallows every request until reset.
module source_code_lexer_top (
	input logic clk,
	input logic arst_n,
	scl_in_if.sink   in_ch,
	scl_out_if.source out_ch
);
	import scl_pkg::*;

	tok_pair_t pair;
	logic      room, q_valid, q_pop;
	token_t    q_tok, out_tok;

	// Front: classify each request and update position state.
	scl_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.cmd(in_ch.cmd), .byte_value(in_ch.byte_value),
		.room, .pair
	);

	// Queue between scanner and output stage.
	scl_queue u_queue (
		.clk, .arst_n, .pair, .room, .q_valid, .q_tok, .q_pop
	);

	// Back: output register.
	scl_back u_back (
		.clk, .arst_n, .q_valid, .q_tok, .q_pop,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_tok
	);

	assign out_ch.token_kind   = out_tok.token_kind;
	assign out_ch.start_line   = out_tok.start_line;
	assign out_ch.start_column = out_tok.start_column;
	assign out_ch.token_length = out_tok.token_length;
	assign out_ch.char_code    = out_tok.char_code;
	assign out_ch.error_code   = out_tok.error_code;
	assign out_ch.last_of_item = out_tok.last_of_item;
endmodule

### rtl/core/scl_checker.sv
// ----------------------------------------------------------------------------
// scl_checker
// Port-level checks on the lexer's result channel.
// ----------------------------------------------------------------------------
`include "source_code_lexer_top_assert.svh"
module scl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  token_kind,
	input logic [1:0]  error_code,
	input logic [15:0] start_line,
	input logic        last_of_item
);
	import scl_pkg::*;

	`SCL_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(token_kind), "result dropped while stalled")
	`SCL_ASSERT_IMP(a_err, clk, arst_n, out_valid && token_kind == K_ERROR, error_code != ERR_NONE && last_of_item, "error token malformed")
	`SCL_ASSERT_IMP(a_noerr, clk, arst_n, out_valid && token_kind != K_ERROR, error_code == ERR_NONE, "error code on normal token")
	`SCL_ASSERT_IMP(a_end, clk, arst_n, out_valid && token_kind == K_END, last_of_item && start_line != 16'd0, "END token malformed")
endmodule

bind source_code_lexer_top scl_checker u_scl_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.token_kind(out_ch.token_kind), .error_code(out_ch.error_code),
	.start_line(out_ch.start_line), .last_of_item(out_ch.last_of_item)
);
